### src/bsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, codes and constants of the bitmap stream to RGB555 converter.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int POS_W       = 22;
  localparam int MAX_DIM_DEF = 256;
  localparam int OUT_DEPTH   = 4;
  localparam int CFG_W       = 22;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_PIXEL    = 2'd0;
  localparam logic [1:0] KIND_FINISHED = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_LENGTH    = 3'd2;
  localparam logic [2:0] ERR_DIMS      = 3'd3;
  localparam logic [2:0] ERR_FORMAT    = 3'd4;
  localparam logic [2:0] ERR_EARLY_END = 3'd5;

  localparam logic [1:0] PIC_ANY    = 2'd0;
  localparam logic [1:0] PIC_FULL   = 2'd1;
  localparam logic [1:0] PIC_STRIP  = 2'd2;
  localparam logic [1:0] PIC_SPRITE = 2'd3;

  localparam logic CFG_PICTURE_KIND = 1'b0;
  localparam logic CFG_FILE_LENGTH  = 1'b1;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  localparam logic [4:0] HP_SIG_B    = 5'd0;
  localparam logic [4:0] HP_SIG_M    = 5'd1;
  localparam logic [4:0] HP_BASE_MUL = 5'd26;
  localparam logic [4:0] HP_BPP_LO   = 5'd28;
  localparam logic [4:0] HP_LAST     = 5'd29;

  localparam logic [31:0] MIN_OFFSET = 32'd30;
  localparam logic [15:0] BPP_24     = 16'd24;
  localparam logic [15:0] BPP_32     = 16'd32;
  localparam logic [31:0] FULL_W     = 32'd240;
  localparam logic [31:0] FULL_H     = 32'd160;
  localparam logic [31:0] STRIP_W    = 32'd240;
  localparam logic [31:0] STRIP_H    = 32'd14;
  localparam logic [31:0] SPRITE_W   = 32'd9;
  localparam logic [31:0] SPRITE_H   = 32'd12;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [14:0] color;
    logic [2:0]  err;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic result_t mk_status(input logic [1:0] kind, input logic [2:0] err);
    result_t r;
    r.kind  = kind;
    r.addr  = '0;
    r.color = '0;
    r.err   = err;
    r.last  = 1'b1;
    return r;
  endfunction

endpackage

### src/bsr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_parser
// Header capture and checks, pixel row walk and colour packing, one byte a
// cycle while bytes are being accepted.
// ----------------------------------------------------------------------------
module bsr_parser #(
  parameter int MAX_DIM = bsr_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic [7:0]               in_data,
  input  logic                     in_last,
  input  logic [1:0]               picture_kind,
  input  logic [bsr_pkg::POS_W-1:0] file_length,
  output bsr_pkg::push_t           push
);
  import bsr_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int LINE_W = $clog2(4 * MAX_DIM + 1);

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       offset_r, offset_nxt;
  logic [31:0]       width_r, width_nxt;
  logic [31:0]       height_r, height_nxt;
  logic [7:0]        bpp_lo_r, bpp_lo_nxt;
  logic              is32_r, is32_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [LINE_W-1:0] bil_r, bil_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [15:0]       base_r, base_nxt;
  logic [15:0]       held_r, held_nxt;
  logic [1:0]        sub_r, sub_nxt;

  logic [4:0]        hp;
  logic [1:0]        lane;
  logic [15:0]       bpp_full;
  logic              sig_bad;
  logic [2:0]        hdr_err;
  logic              hdr_end;
  logic              empty_pic;
  logic [POS_W-1:0]  pos_inc;
  logic              skip_hit;
  logic [DIM_W-1:0]  width_s;
  logic [DIM_W-1:0]  height_s;
  logic              col_active;
  logic              pix_emit;
  logic              sub_wrap;
  logic [LINE_W-1:0] bil_inc;
  logic              line_end;
  logic              pic_end;
  logic [31:0]       base_prod;
  logic [LINE_W-1:0] line24;
  logic              a_v, b_v, c_v;
  result_t           a_r;

  assign hp       = pos_r[4:0];
  assign lane     = 2'(hp - 5'd2);
  assign bpp_full = {in_data, bpp_lo_r};
  assign pos_inc  = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
  assign skip_hit = ({{(32-POS_W){1'b0}}, pos_inc} == offset_r);
  assign width_s  = width_r[DIM_W-1:0];
  assign height_s = height_r[DIM_W-1:0];
  assign bil_inc  = bil_r + 1'b1;
  assign base_prod = 32'(height_r[15:0] - 16'd1) * 32'(width_r[15:0]);
  assign line24   = LINE_W'((LINE_W'(width_s) * LINE_W'(3) + LINE_W'(3)) >> 2) << 2;

  always_comb begin
    hdr_err = ERR_NONE;
    if (size_r != {{(32-POS_W){1'b0}}, file_length}) begin
      hdr_err = ERR_LENGTH;
    end else if ((picture_kind == PIC_FULL && (width_r != FULL_W || height_r != FULL_H)) ||
                 (picture_kind == PIC_STRIP && (width_r != STRIP_W || height_r != STRIP_H)) ||
                 (picture_kind == PIC_SPRITE &&
                  (width_r != SPRITE_W || height_r != SPRITE_H)) ||
                 width_r > 32'(MAX_DIM) || height_r > 32'(MAX_DIM)) begin
      hdr_err = ERR_DIMS;
    end else if ((bpp_full != BPP_24 && bpp_full != BPP_32) || offset_r < MIN_OFFSET) begin
      hdr_err = ERR_FORMAT;
    end
  end

  always_comb begin
    sig_bad    = (phase_r == PH_HEADER) &&
                 ((hp == HP_SIG_B && in_data != SIG_B) || (hp == HP_SIG_M && in_data != SIG_M));
    hdr_end    = (phase_r == PH_HEADER) && (hp == HP_LAST);
    empty_pic  = (width_r == 32'd0) || (height_r == 32'd0);
    col_active = (phase_r == PH_PIXELS) && (col_r < width_s);
    pix_emit   = col_active && (sub_r == 2'd2);
    sub_wrap   = (sub_r == (is32_r ? 2'd3 : 2'd2));
    line_end   = (phase_r == PH_PIXELS) && (bil_inc == line_r);
    pic_end    = line_end && ((row_r + 1'b1) == height_s);
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (sig_bad) begin
          phase_nxt = PH_DONE;
        end else if (hdr_end) begin
          if (hdr_err != ERR_NONE || empty_pic) begin
            phase_nxt = PH_DONE;
          end else if (offset_r == MIN_OFFSET) begin
            phase_nxt = PH_PIXELS;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (skip_hit) begin
          phase_nxt = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (pic_end) begin
          phase_nxt = PH_DONE;
        end
      end
      default: phase_nxt = phase_r;
    endcase
    if (in_last) begin
      phase_nxt = PH_HEADER;
    end
  end

  always_comb begin
    a_r = mk_status(KIND_ERROR, ERR_SIGNATURE);
    a_v = 1'b0;
    if (sig_bad) begin
      a_v = 1'b1;
    end else if (hdr_end && hdr_err != ERR_NONE) begin
      a_v = 1'b1;
      a_r = mk_status(KIND_ERROR, hdr_err);
    end else if (hdr_end && empty_pic) begin
      a_v = 1'b1;
      a_r = mk_status(KIND_FINISHED, ERR_NONE);
    end else if (pix_emit) begin
      a_v       = 1'b1;
      a_r.kind  = KIND_PIXEL;
      a_r.addr  = base_r + 16'(col_r);
      a_r.color = {held_r[15:11], held_r[7:3], in_data[7:3]};
      a_r.err   = ERR_NONE;
      a_r.last  = 1'b0;
    end
    b_v = pic_end;
    c_v = in_last && (phase_r != PH_DONE) && !sig_bad &&
          !(hdr_end && (hdr_err != ERR_NONE || empty_pic)) && !pic_end;

    push.v0 = 1'b0;
    push.v1 = 1'b0;
    push.r0 = a_r;
    push.r1 = mk_status(KIND_ERROR, ERR_EARLY_END);
    if (a_v) begin
      push.v0 = in_fire;
      push.v1 = in_fire && (b_v || c_v);
      if (b_v) begin
        push.r1 = mk_status(KIND_FINISHED, ERR_NONE);
      end
    end else if (b_v) begin
      push.v0 = in_fire;
      push.r0 = mk_status(KIND_FINISHED, ERR_NONE);
    end else if (c_v) begin
      push.v0 = in_fire;
      push.r0 = mk_status(KIND_ERROR, ERR_EARLY_END);
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    size_nxt   = size_r;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bpp_lo_nxt = bpp_lo_r;
    is32_nxt   = is32_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    bil_nxt    = bil_r;
    line_nxt   = line_r;
    base_nxt   = base_r;
    held_nxt   = held_r;
    sub_nxt    = sub_r;
    case (phase_r)
      PH_HEADER: begin
        if (!sig_bad) begin
          pos_nxt = pos_r + 1'b1;
          case (hp) inside
            [5'd2:5'd5]:   size_nxt[{lane, 3'b000} +: 8] = in_data;
            [5'd10:5'd13]: offset_nxt[{lane, 3'b000} +: 8] = in_data;
            [5'd18:5'd21]: width_nxt[{lane, 3'b000} +: 8] = in_data;
            [5'd22:5'd25]: height_nxt[{lane, 3'b000} +: 8] = in_data;
            HP_BPP_LO:     bpp_lo_nxt = in_data;
            default: ;
          endcase
          if (hp == HP_BASE_MUL) begin
            base_nxt = base_prod[15:0];
          end
          if (hdr_end) begin
            is32_nxt = (bpp_full == BPP_32);
            line_nxt = (bpp_full == BPP_32) ? LINE_W'({width_s, 2'b00}) : line24;
            col_nxt  = '0;
            row_nxt  = '0;
            bil_nxt  = '0;
            sub_nxt  = '0;
            held_nxt = '0;
          end
        end
      end
      PH_SKIP: begin
        pos_nxt = pos_inc;
      end
      PH_PIXELS: begin
        pos_nxt = pos_inc;
        bil_nxt = bil_inc;
        if (col_active) begin
          if (sub_r < 2'd2) begin
            held_nxt = {held_r[7:0], in_data};
          end
          if (sub_wrap) begin
            sub_nxt = '0;
            col_nxt = col_r + 1'b1;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
        if (line_end) begin
          bil_nxt  = '0;
          col_nxt  = '0;
          sub_nxt  = '0;
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r - width_r[15:0];
        end
      end
      default: ;
    endcase
    if (in_last) begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      size_r   <= size_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_lo_r <= bpp_lo_nxt;
      is32_r   <= is32_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bil_r    <= bil_nxt;
      line_r   <= line_nxt;
      base_r   <= base_nxt;
      held_r   <= held_nxt;
      sub_r    <= sub_nxt;
    end
  end

endmodule

### src/bsr_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_out_fifo
// Small result queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module bsr_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  bsr_pkg::push_t   push,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output bsr_pkg::result_t out_res
);
  import bsr_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  result_t           mem [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pop;
  logic [PTR_W-1:0]  wr_p1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rd_r];
  assign room2     = (cnt_r <= CNT_W'(OUT_DEPTH - 2));
  assign wr_p1     = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.v0) + PTR_W'(push.v1);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_p1] <= push.r1;
    end
  end

endmodule

### src/bmp_stream_to_rgb555_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb555_top
// Bitmap file byte stream in, RGB555 pixels with buffer addresses and a
// closing status out.
// ----------------------------------------------------------------------------
//  Channel  Direction  Request
//  in_      slave      one file byte, tlast on the final byte of the file
//  out_     master     one pixel or status result, tlast on the closing status
//  cfg_     write      picture kind (index 0) or file length (index 1)
//
// One byte is taken every cycle; its results are written into a four-entry
// queue in the same cycle. in_tready is low only while fewer than two queue
// entries are free, so a stalled output holds back the input after three or
// four results. Reset is synchronous and returns the parser to the header.
// ----------------------------------------------------------------------------
module bmp_stream_to_rgb555_top #(
  parameter int MAX_DIM = bsr_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // data_byte
  input  logic                      in_tlast,   // last_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [39:0]               out_tdata,  // pixel_address, color, error_code
  output logic [1:0]                out_tuser,  // kind
  output logic                      out_tlast,  // last
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [bsr_pkg::CFG_W-1:0] cfg_wdata
);
  import bsr_pkg::*;

  logic [1:0]       kind_r;
  logic [POS_W-1:0] flen_r;
  logic             in_fire;
  logic             room2;
  push_t            push;
  result_t          res;

  assign in_tready = room2;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= PIC_ANY;
      flen_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_PICTURE_KIND) begin
        kind_r <= cfg_wdata[1:0];
      end else begin
        flen_r <= cfg_wdata[POS_W-1:0];
      end
    end
  end

  bsr_parser #(
    .MAX_DIM(MAX_DIM)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_data      (in_tdata),
    .in_last      (in_tlast),
    .picture_kind (kind_r),
    .file_length  (flen_r),
    .push         (push)
  );

  bsr_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {6'b0, res.err, res.color, res.addr};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> in_fire) else $error("result written without an accepted byte");

  a_second_is_closing: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && push.r1.last && !push.r0.last))
    else $error("second result of a byte is not the closing status");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !room2 |-> !push.v0) else $error("result written into a full queue");

endmodule

### tb/bmp_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap decode scoreboard
// Follows the bitmap byte stream as the converter should: it captures the
// header words, checks them against the register settings, walks the padded
// pixel rows bottom-up and queues every pixel and closing status that each
// accepted byte must produce. Results from the block are then compared, field
// by field, with the oldest queued entry.
// ----------------------------------------------------------------------------
package bmp_scoreboard_pkg;
  import bsr_pkg::*;

  class bmp_scoreboard;
    logic [1:0]  picture_kind;
    logic [21:0] file_length;
    int          dim_limit;
    result_t     results_due[$];
    int          failures;

    phase_t      phase;
    logic [21:0] byte_pos;
    logic [31:0] declared_size;
    logic [31:0] pixel_offset;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [15:0] bits_per_pixel;
    int unsigned column;
    int unsigned row;
    int unsigned byte_in_line;
    int unsigned pixel_sub;
    logic [15:0] row_base;
    logic [15:0] held_bytes;

    function new(int max_dim);
      dim_limit    = max_dim;
      picture_kind = PIC_ANY;
      file_length  = '0;
      failures     = 0;
      restart();
    endfunction

    function void restart();
      phase          = PH_HEADER;
      byte_pos       = '0;
      declared_size  = '0;
      pixel_offset   = '0;
      image_width    = '0;
      image_height   = '0;
      bits_per_pixel = '0;
      column         = 0;
      row            = 0;
      byte_in_line   = 0;
      pixel_sub      = 0;
      row_base       = '0;
      held_bytes     = '0;
    endfunction

    function void push_status(logic [1:0] kind, logic [2:0] code);
      result_t r;
      r.kind  = kind;
      r.addr  = '0;
      r.color = '0;
      r.err   = code;
      r.last  = 1'b1;
      results_due.push_back(r);
    endfunction

    function logic [2:0] header_error();
      if (declared_size != 32'(file_length)) return ERR_LENGTH;
      if (picture_kind == PIC_FULL && (image_width != FULL_W || image_height != FULL_H))
        return ERR_DIMS;
      if (picture_kind == PIC_STRIP && (image_width != STRIP_W || image_height != STRIP_H))
        return ERR_DIMS;
      if (picture_kind == PIC_SPRITE && (image_width != SPRITE_W || image_height != SPRITE_H))
        return ERR_DIMS;
      if (image_width > dim_limit || image_height > dim_limit) return ERR_DIMS;
      if (bits_per_pixel != BPP_24 && bits_per_pixel != BPP_32) return ERR_FORMAT;
      if (pixel_offset < MIN_OFFSET) return ERR_FORMAT;
      return ERR_NONE;
    endfunction

    function void decode_byte(logic [7:0] d, logic final_flag);
      int unsigned p;
      int unsigned line_bytes;
      int unsigned bpp_bytes;
      logic [2:0]  code;
      result_t     r;
      p = byte_pos;
      case (phase)
        PH_HEADER: begin
          if ((p == HP_SIG_B && d != SIG_B) || (p == HP_SIG_M && d != SIG_M)) begin
            push_status(KIND_ERROR, ERR_SIGNATURE);
            phase = PH_DONE;
          end else begin
            if (p >= 2 && p <= 5) declared_size[8*(p-2) +: 8] = d;
            else if (p >= 10 && p <= 13) pixel_offset[8*(p-10) +: 8] = d;
            else if (p >= 18 && p <= 21) image_width[8*(p-18) +: 8] = d;
            else if (p >= 22 && p <= 25) image_height[8*(p-22) +: 8] = d;
            else if (p >= HP_BPP_LO && p <= HP_LAST) bits_per_pixel[8*(p-HP_BPP_LO) +: 8] = d;
            byte_pos = 22'(p + 1);
            if (p == HP_LAST) begin
              code = header_error();
              if (code != ERR_NONE) begin
                push_status(KIND_ERROR, code);
                phase = PH_DONE;
              end else if (image_width == 0 || image_height == 0) begin
                push_status(KIND_FINISHED, ERR_NONE);
                phase = PH_DONE;
              end else begin
                column       = 0;
                row          = 0;
                byte_in_line = 0;
                pixel_sub    = 0;
                held_bytes   = '0;
                row_base     = 16'((image_height - 1) * image_width);
                if (pixel_offset == MIN_OFFSET) phase = PH_PIXELS;
                else phase = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (byte_pos < POS_MAX) byte_pos++;
          if (32'(byte_pos) == pixel_offset) phase = PH_PIXELS;
        end
        PH_PIXELS: begin
          bpp_bytes  = bits_per_pixel >> 3;
          line_bytes = (bits_per_pixel == BPP_32) ? image_width * 4
                                                  : ((image_width * 3 + 3) >> 2) << 2;
          if (byte_pos < POS_MAX) byte_pos++;
          if (column < image_width) begin
            if (pixel_sub < 2) begin
              held_bytes = {held_bytes[7:0], d};
            end else if (pixel_sub == 2) begin
              r.kind  = KIND_PIXEL;
              r.addr  = row_base + 16'(column);
              r.color = {held_bytes[15:11], held_bytes[7:3], d[7:3]};
              r.err   = ERR_NONE;
              r.last  = 1'b0;
              results_due.push_back(r);
            end
            if (pixel_sub + 1 >= bpp_bytes) begin
              pixel_sub = 0;
              column++;
            end else begin
              pixel_sub++;
            end
          end
          byte_in_line++;
          if (byte_in_line >= line_bytes) begin
            byte_in_line = 0;
            column       = 0;
            pixel_sub    = 0;
            row++;
            row_base = row_base - 16'(image_width);
            if (row >= image_height) begin
              push_status(KIND_FINISHED, ERR_NONE);
              phase = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
      if (final_flag) begin
        if (phase != PH_DONE) push_status(KIND_ERROR, ERR_EARLY_END);
        restart();
      end
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [15:0] addr, logic [14:0] color,
                               logic [2:0] code, logic last_flag);
      result_t e;
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d address %0d colour %0d code %0d last %0d",
               kind, addr, color, code, last_flag);
        failures++;
        return;
      end
      e = results_due.pop_front();
      compare("kind", e.kind, kind);
      compare("pixel_address", e.addr, addr);
      compare("color", e.color, color);
      compare("error_code", e.err, code);
      compare("last", e.last, last_flag);
    endfunction

    function int close();
      if (results_due.size() != 0) begin
        $error("%0d expected results never arrived", results_due.size());
        failures++;
      end
      return failures;
    endfunction
  endclass

endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the bitmap stream to RGB555 converter
// Streams whole bitmap files into the block, byte by byte in bursts, while the
// result side stalls on its own pattern. A directed set covers the header
// checks, padding, skipping, early ends and each picture kind; random files,
// mostly well formed with random pixels, follow under changing register
// settings. Every result is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb;
  import bsr_pkg::*;
  import bmp_scoreboard_pkg::*;

  localparam int DIM_LIMIT    = MAX_DIM_DEF;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_BYTES = 250;
  localparam int ROWS_ALL     = 100000;
  localparam int FILLER_CAP   = 64;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_we     = 1'b0;
  logic              cfg_addr   = CFG_PICTURE_KIND;
  logic [CFG_W-1:0]  cfg_wdata  = '0;

  bmp_scoreboard sb;
  logic [7:0]    file_bytes[$];
  int            burst_left  = 0;
  int            cycle_count = 0;

  bmp_stream_to_rgb555_top #(
    .MAX_DIM(DIM_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata[15:0], out_tdata[30:16], out_tdata[33:31],
                      out_tlast);
    end
  end

  initial begin
    int ready_pct;
    int span;
    forever begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 50;
        2: ready_pct = 80;
        default: ready_pct = 0;
      endcase
      span = (ready_pct == 0) ? $urandom_range(1, 20) : $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        out_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_byte(input logic [7:0] value, input logic final_flag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= final_flag;
    do @(posedge clk); while (!in_tready);
    sb.decode_byte(value, final_flag);
    burst_left--;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(input logic [1:0] kind, input logic [21:0] length);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PICTURE_KIND;
    cfg_wdata <= CFG_W'(kind);
    @(posedge clk);
    cfg_addr  <= CFG_FILE_LENGTH;
    cfg_wdata <= length;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.picture_kind = kind;
    sb.file_length  = length;
  endtask

  // Builds a bitmap with the given header words and random pixel bytes, then
  // optionally cuts it short, appends trailing bytes or spoils the signature.
  task automatic run_bitmap(input logic [31:0] declared, input logic [31:0] offset,
                            input logic [31:0] width, input logic [31:0] height,
                            input logic [15:0] bpp, input int keep, input int extra,
                            input int sig_fault, input int max_rows);
    logic [7:0]  hdr [30];
    int unsigned filler;
    int unsigned line_bytes;
    int unsigned rows;
    file_bytes.delete();
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = SIG_B;
    hdr[1] = SIG_M;
    for (int i = 0; i < 4; i++) begin
      hdr[2 + i]  = declared[8*i +: 8];
      hdr[10 + i] = offset[8*i +: 8];
      hdr[18 + i] = width[8*i +: 8];
      hdr[22 + i] = height[8*i +: 8];
    end
    hdr[28] = bpp[7:0];
    hdr[29] = bpp[15:8];
    if (sig_fault == 1) hdr[0] ^= 8'($urandom_range(1, 255));
    if (sig_fault == 2) hdr[1] ^= 8'($urandom_range(1, 255));
    foreach (hdr[i]) file_bytes.push_back(hdr[i]);
    filler = (offset > MIN_OFFSET) ? offset - MIN_OFFSET : 0;
    if (filler > FILLER_CAP) filler = FILLER_CAP;
    repeat (filler) file_bytes.push_back(8'($urandom));
    if (offset >= MIN_OFFSET && offset - MIN_OFFSET <= FILLER_CAP && width >= 1 &&
        width <= DIM_LIMIT && height >= 1 && height <= DIM_LIMIT &&
        (bpp == BPP_24 || bpp == BPP_32)) begin
      line_bytes = (bpp == BPP_32) ? width * 4 : ((width * 3 + 3) >> 2) << 2;
      rows = (height < max_rows) ? height : max_rows;
      repeat (line_bytes * rows) file_bytes.push_back(8'($urandom));
    end
    if (keep > 0) begin
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
    repeat (extra) file_bytes.push_back(8'($urandom));
    send_file();
  endtask

  initial begin
    logic [31:0] declared;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] bpp;
    logic [1:0]  cur_kind;
    logic [21:0] cur_length;
    int          keep;
    int          extra;
    int          sig_fault;
    int          counted;
    int          files_left;
    bit          noise;

    sb = new(DIM_LIMIT);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: any size, file length zero.
    run_bitmap(0, 30, 2, 2, BPP_24, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 34, 3, 2, BPP_32, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, 4, 2, BPP_24, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, 1, 3, BPP_24, 0, 5, 0, ROWS_ALL);
    run_bitmap(0, 30, 2, 2, BPP_24, 33, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, 2, 2, BPP_24, 11, 0, 0, ROWS_ALL);
    run_bitmap(0, 33, 2, 2, BPP_24, 31, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, 2, 2, BPP_24, 0, 3, 1, ROWS_ALL);
    run_bitmap(0, 30, 2, 2, BPP_24, 0, 3, 2, ROWS_ALL);
    run_bitmap(1, 30, 2, 2, BPP_24, 0, 0, 0, ROWS_ALL);
    run_bitmap(7, 29, 300, 2, 16'd8, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, 0, 5, BPP_24, 0, 3, 0, ROWS_ALL);
    run_bitmap(0, 30, 5, 0, BPP_32, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, DIM_LIMIT + 1, 1, BPP_24, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, 2, 32'hFFFF_FFFE, BPP_24, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, DIM_LIMIT, 1, BPP_24, 40, 0, 0, ROWS_ALL);
    run_bitmap(0, 31, 1, DIM_LIMIT, BPP_32, 40, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, 2, 2, 16'd16, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 30, 2, 2, 16'h0118, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 29, 2, 2, BPP_24, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 0, 2, 2, BPP_32, 0, 0, 0, ROWS_ALL);
    run_bitmap(0, 32'h0040_0000, 2, 2, BPP_24, 0, 20, 0, ROWS_ALL);
    file_bytes = '{SIG_B};
    send_file();
    file_bytes = '{8'h00, 8'hFF};
    send_file();
    drain();

    set_registers(PIC_ANY, POS_MAX);
    run_bitmap(POS_MAX, 30, 1, 1, BPP_32, 0, 0, 0, ROWS_ALL);
    run_bitmap(32'hFFFF_FFFF, 30, 1, 1, BPP_32, 0, 0, 0, ROWS_ALL);
    drain();

    // The picture kind pictures are cut short to keep the run brief.
    set_registers(PIC_SPRITE, 366);
    run_bitmap(366, 30, SPRITE_W, SPRITE_H, BPP_24, 0, 0, 0, 2);
    run_bitmap(366, 30, SPRITE_W, SPRITE_H - 1, BPP_24, 35, 0, 0, ROWS_ALL);
    run_bitmap(366, 30, SPRITE_H, SPRITE_W, BPP_24, 35, 0, 0, ROWS_ALL);
    drain();

    set_registers(PIC_STRIP, 10110);
    run_bitmap(10110, 30, STRIP_W, STRIP_H, BPP_24, 40, 0, 0, 1);
    run_bitmap(10110, 30, STRIP_W, STRIP_H - 1, BPP_24, 40, 0, 0, 1);
    drain();

    set_registers(PIC_FULL, 153630);
    run_bitmap(153630, 30, FULL_W, FULL_H, BPP_32, 40, 0, 0, 1);
    run_bitmap(153630, 30, FULL_H, FULL_W, BPP_32, 40, 0, 0, 1);

    counted    = 0;
    files_left = 0;
    cur_kind   = PIC_ANY;
    cur_length = '0;
    while (counted < RANDOM_BYTES) begin
      if (files_left == 0) begin
        drain();
        case ($urandom_range(0, 9))
          6, 7: cur_kind = PIC_SPRITE;
          8: cur_kind = PIC_FULL;
          9: cur_kind = PIC_STRIP;
          default: cur_kind = PIC_ANY;
        endcase
        case ($urandom_range(0, 3))
          0: cur_length = '0;
          1: cur_length = POS_MAX;
          default: cur_length = 22'($urandom);
        endcase
        set_registers(cur_kind, cur_length);
        files_left = $urandom_range(4, 10);
      end

      width  = $urandom_range(1, 8);
      height = $urandom_range(1, 5);
      if ($urandom_range(0, 7) == 0) begin
        width  = $urandom_range(9, 40);
        height = $urandom_range(1, 3);
      end
      if (cur_kind == PIC_SPRITE && $urandom_range(0, 3) != 0) begin
        width  = SPRITE_W;
        height = SPRITE_H;
      end
      bpp       = $urandom_range(0, 1) ? BPP_32 : BPP_24;
      offset    = ($urandom_range(0, 2) == 0) ? MIN_OFFSET : $urandom_range(31, 45);
      declared  = 32'(cur_length);
      keep      = 0;
      extra     = 0;
      sig_fault = 0;
      noise     = 1'b0;

      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          1: extra = $urandom_range(1, 6);
          2: keep = $urandom_range(1, width * height * 4 + 60);
          default: begin
          end
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0: sig_fault = 1;
          1: sig_fault = 2;
          2: declared ^= 32'd1 << $urandom_range(0, 31);
          3: bpp = 16'($urandom);
          4: offset = $urandom_range(0, 29);
          5: width = $urandom_range(DIM_LIMIT + 1, 2000);
          6: height = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 10)
                                           : $urandom_range(DIM_LIMIT + 1, 5000);
          7: if ($urandom_range(0, 1)) width = 0; else height = 0;
          8: offset = $urandom | 32'h0040_0000;
          default: noise = 1'b1;
        endcase
        extra = $urandom_range(0, 4);
      end

      if (noise) begin
        file_bytes.delete();
        repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom));
        send_file();
        counted += file_bytes.size();
      end else begin
        run_bitmap(declared, offset, width, height, bpp, keep, extra, sig_fault, ROWS_ALL);
        counted += file_bytes.size() - extra;
      end
      files_left--;
      if ($urandom_range(0, 11) == 0) drain();
    end

    drain();
    repeat (16) @(posedge clk);
    if (sb.close() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
src/bsr_pkg.sv
src/bsr_parser.sv
src/bsr_out_fifo.sv
src/bmp_stream_to_rgb555_top.sv
tb/bmp_scoreboard_pkg.sv
tb/tb.sv
